// ===== hdl/bffa_pkg.sv =====
`default_nettype none
package bffa_pkg;

    localparam int NUM_BLOCKS    = 64;
    localparam int BLOCK_ENTRIES = 4;

    // field widths fixed by the interface
    localparam int CMD_W   = 1;
    localparam int LEN_W   = 9;
    localparam int BLK_W   = 6;
    localparam int STAT_W  = 2;
    localparam int ADDR_W  = 8;

    // internal widths
    localparam int IDX_W   = $clog2(NUM_BLOCKS);
    localparam int RUN_W   = IDX_W + 1;
    localparam int WIDE_W  = ((RUN_W > LEN_W) ? RUN_W : LEN_W) + 2;
    localparam int SW      = (IDX_W > BLK_W) ? IDX_W : BLK_W;
    localparam int EA_W    = SW + 8;

    // ceil(len / BLOCK_ENTRIES) as a multiply by a scaled reciprocal
    localparam int SUM_W   = LEN_W + 1;
    localparam int RECIP_S = SUM_W + 7;
    localparam int RECIP_M = ((2 ** RECIP_S) + BLOCK_ENTRIES - 1) / BLOCK_ENTRIES;
    localparam int PROD_W  = SUM_W + RECIP_S + 1;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOFIT  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADREL = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [LEN_W-1:0] request_length;
        logic [BLK_W-1:0] release_block;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BLK_W-1:0]  start_block;
        logic [ADDR_W-1:0] entry_address;
    } rsp_t;

    // scan token that walks the cell chain
    typedef struct packed {
        logic [RUN_W-1:0] run;
        logic             any_free;
        logic             found;
        logic [IDX_W-1:0] start;
    } token_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic [LEN_W-1:0] n;
        logic             op_en;
        logic             op_set;
        logic [IDX_W-1:0] lo;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/bitmap_first_fit_block_allocator.sv =====
`default_nettype none
// First-fit contiguous block allocator over a used-bit map.
// Command channel: present request while start is high; the beat is taken
// on the edge where start is high and busy is low. busy stays high until
// the request is finished; no new command is taken meanwhile.
// Result channel: done pulses for one cycle with result; the receiver
// cannot stall, so the result must be taken in that cycle.
// A release is carried out in the scan state that follows its acceptance;
// done shows in the cycle after that. An allocate walks a scan token down
// the chain of cells, one cell per cycle, and finishes once the token has
// left the last cell. Each cell holds one map bit; the grant or release of
// a run writes all affected cells in the same cycle.
// A new command may be taken in the same cycle that done is high.
// Reset clears every map bit (all blocks free) and the command sequencer.
module bitmap_first_fit_block_allocator
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire bffa_pkg::req_t    request,
    output logic                   busy,
    output logic                   done,
    output bffa_pkg::rsp_t         result
);

    bffa_pkg::token_t      tok [bffa_pkg::NUM_BLOCKS+1];
    bffa_pkg::cell_ctrl_t  ctl;

    // fresh token enters the head of the chain every cycle
    assign tok[0] = '0;

    for (genvar i = 0; i < bffa_pkg::NUM_BLOCKS; i++)
    begin : g_cell
        bffa_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .index   (bffa_pkg::IDX_W'(i)),
            .ctl     (ctl),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    bffa_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .tail    (tok[bffa_pkg::NUM_BLOCKS]),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .ctl     (ctl)
    );

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a command in progress");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != bffa_pkg::ST_OK))
        |-> ((result.start_block == '0) && (result.entry_address == '0)))
        else $error("failed request returned a nonzero address");
`endif

endmodule
`default_nettype wire

// ===== hdl/bffa_cell.sv =====
`default_nettype none
module bffa_cell
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [bffa_pkg::IDX_W-1:0]    index,
    input  wire bffa_pkg::cell_ctrl_t          ctl,
    input  wire bffa_pkg::token_t              tok_in,
    output bffa_pkg::token_t                   tok_out
);

    logic                          used_reg;
    logic                          used_next;
    bffa_pkg::token_t              tok_reg;
    bffa_pkg::token_t              tok_next;
    logic [bffa_pkg::RUN_W-1:0]    run1;
    logic [bffa_pkg::WIDE_W-1:0]   idx_w;
    logic [bffa_pkg::WIDE_W-1:0]   lo_w;
    logic [bffa_pkg::WIDE_W-1:0]   n_w;
    logic [bffa_pkg::WIDE_W-1:0]   run1_w;
    logic [bffa_pkg::WIDE_W-1:0]   fit_start;
    logic                          in_range;

    assign idx_w     = bffa_pkg::WIDE_W'(index);
    assign lo_w      = bffa_pkg::WIDE_W'(ctl.lo);
    assign n_w       = bffa_pkg::WIDE_W'(ctl.n);
    assign run1      = tok_in.run + bffa_pkg::RUN_W'(1);
    assign run1_w    = bffa_pkg::WIDE_W'(run1);
    assign fit_start = idx_w + bffa_pkg::WIDE_W'(1) - n_w;
    assign in_range  = (index >= ctl.lo) && (idx_w < (lo_w + n_w));

    always_comb
    begin
        used_next = used_reg;
        if (ctl.op_en && in_range)
        begin
            used_next = ctl.op_set;
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.found)
        begin
            if (used_reg)
            begin
                tok_next.run = '0;
            end
            else
            begin
                tok_next.run      = run1;
                tok_next.any_free = 1'b1;
                if (!tok_in.any_free && (ctl.n == '0))
                begin
                    // zero length: report the lowest free block
                    tok_next.found = 1'b1;
                    tok_next.start = index;
                end
                else if ((ctl.n != '0) && (run1_w >= n_w))
                begin
                    tok_next.found = 1'b1;
                    tok_next.start = fit_start[bffa_pkg::IDX_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;

endmodule
`default_nettype wire

// ===== hdl/bffa_ctrl.sv =====
`default_nettype none
module bffa_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire bffa_pkg::req_t        request,
    input  wire bffa_pkg::token_t      tail,
    output logic                       busy,
    output logic                       done,
    output bffa_pkg::rsp_t             result,
    output bffa_pkg::cell_ctrl_t       ctl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    function automatic bffa_pkg::rsp_t make_rsp(
        input logic [bffa_pkg::STAT_W-1:0] st,
        input logic [bffa_pkg::SW-1:0]     sb
    );
        bffa_pkg::rsp_t              r;
        logic [bffa_pkg::EA_W-1:0]   ea;
        ea = bffa_pkg::EA_W'(sb) * bffa_pkg::EA_W'(bffa_pkg::BLOCK_ENTRIES);
        r.status        = st;
        r.start_block   = sb[bffa_pkg::BLK_W-1:0];
        r.entry_address = ea[bffa_pkg::ADDR_W-1:0];
        return r;
    endfunction

    logic                              state_reg, state_next;
    logic [bffa_pkg::RUN_W-1:0]        cnt_reg, cnt_next;
    logic [bffa_pkg::CMD_W-1:0]        cmd_reg, cmd_next;
    logic [bffa_pkg::BLK_W-1:0]        rel_reg, rel_next;
    logic [bffa_pkg::LEN_W-1:0]        n_reg, n_next;
    logic                              done_reg, done_next;
    bffa_pkg::rsp_t                    rsp_reg, rsp_next;

    logic [bffa_pkg::SUM_W-1:0]        len_sum;
    logic [bffa_pkg::PROD_W-1:0]       len_prod;
    logic [bffa_pkg::WIDE_W-1:0]       rel_end;
    logic [bffa_pkg::SW-1:0]           rel_sw;

    assign len_sum  = bffa_pkg::SUM_W'(request.request_length)
                    + bffa_pkg::SUM_W'(bffa_pkg::BLOCK_ENTRIES - 1);
    assign len_prod = bffa_pkg::PROD_W'(len_sum) * bffa_pkg::PROD_W'(bffa_pkg::RECIP_M);
    assign rel_end  = bffa_pkg::WIDE_W'(rel_reg) + bffa_pkg::WIDE_W'(n_reg);
    assign rel_sw   = bffa_pkg::SW'(rel_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd_next   = cmd_reg;
        rel_next   = rel_reg;
        n_next     = n_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        ctl.n      = n_reg;
        ctl.op_en  = 1'b0;
        ctl.op_set = 1'b0;
        ctl.lo     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = request.command;
                    rel_next   = request.release_block;
                    n_next     = len_prod[bffa_pkg::RECIP_S +: bffa_pkg::LEN_W];
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cmd_reg == bffa_pkg::CMD_RELEASE)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (rel_end > bffa_pkg::WIDE_W'(bffa_pkg::NUM_BLOCKS))
                    begin
                        rsp_next = make_rsp(bffa_pkg::ST_BADREL, '0);
                    end
                    else
                    begin
                        ctl.op_en = (n_reg != '0);
                        ctl.lo    = rel_sw[bffa_pkg::IDX_W-1:0];
                        rsp_next  = make_rsp(bffa_pkg::ST_OK, rel_sw);
                    end
                end
                else if (cnt_reg == bffa_pkg::RUN_W'(bffa_pkg::NUM_BLOCKS))
                begin
                    // token has left the last cell
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (tail.found)
                    begin
                        ctl.op_en  = (n_reg != '0);
                        ctl.op_set = 1'b1;
                        ctl.lo     = tail.start;
                        rsp_next   = make_rsp(bffa_pkg::ST_OK, bffa_pkg::SW'(tail.start));
                    end
                    else if (tail.any_free)
                    begin
                        rsp_next = make_rsp(bffa_pkg::ST_NOFIT, '0);
                    end
                    else
                    begin
                        rsp_next = make_rsp(bffa_pkg::ST_FULL, '0);
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + bffa_pkg::RUN_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        rel_reg <= rel_next;
        n_reg   <= n_next;
        rsp_reg <= rsp_next;
    end

    assign busy   = (state_reg == S_SCAN);
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    import bffa_pkg::*;

    typedef struct {
        req_t req;
        bit   known;
        rsp_t rsp;
    } row_t;

    typedef struct {
        logic [BLK_W-1:0] first;
        int               blocks;
    } run_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t request = '0;
    logic busy;
    logic done;
    rsp_t result;

    bitmap_first_fit_block_allocator dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always #6 clk = ~clk;

    logic [NUM_BLOCKS-1:0] blocks_used = '0;
    rsp_t                  pending_results[$];
    row_t                  directed[$];
    run_t                  live_runs[$];
    int                    mismatches = 0;
    int                    beats_sent = 0;
    int                    results_seen = 0;
    int                    status_seen[4] = '{default: 0};
    int                    nogap_left = 0;

    function automatic int blocks_for(logic [LEN_W-1:0] len);
        return (int'(len) + BLOCK_ENTRIES - 1) / BLOCK_ENTRIES;
    endfunction

    function automatic rsp_t granted(int first);
        rsp_t o;
        o = '0;
        o.status        = ST_OK;
        o.start_block   = BLK_W'(first);
        o.entry_address = ADDR_W'(first * BLOCK_ENTRIES);
        return o;
    endfunction

    // First-fit prediction; updates the shadow map as the block should.
    function automatic rsp_t service_request(req_t r);
        rsp_t o;
        int   n;
        int   run;
        bit   any_free;
        o        = '0;
        n        = blocks_for(r.request_length);
        run      = 0;
        any_free = 1'b0;
        if (r.command == CMD_RELEASE)
        begin
            if (int'(r.release_block) + n > NUM_BLOCKS)
            begin
                o.status = ST_BADREL;
                return o;
            end
            for (int i = 0; i < n; i++)
                blocks_used[int'(r.release_block) + i] = 1'b0;
            return granted(int'(r.release_block));
        end
        for (int i = 0; i < NUM_BLOCKS; i++)
        begin
            if (blocks_used[i])
                run = 0;
            else
            begin
                // zero length answers with the lowest free block, marks nothing
                if (!any_free && n == 0)
                    return granted(i);
                any_free = 1'b1;
                run++;
                if (run >= n)
                begin
                    for (int k = i + 1 - n; k <= i; k++)
                        blocks_used[k] = 1'b1;
                    return granted(i + 1 - n);
                end
            end
        end
        o.status = any_free ? ST_NOFIT : ST_FULL;
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        if (nogap_left > 0)
        begin
            nogap_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            nogap_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    task automatic add_row(input logic [CMD_W-1:0] cmd, input int len, input int blk,
                           input bit known, input logic [STAT_W-1:0] st,
                           input int sb, input int ea);
        row_t row;
        row.req.command        = cmd;
        row.req.request_length = LEN_W'(len);
        row.req.release_block  = BLK_W'(blk);
        row.known              = known;
        row.rsp.status         = st;
        row.rsp.start_block    = BLK_W'(sb);
        row.rsp.entry_address  = ADDR_W'(ea);
        directed.push_back(row);
    endtask

    // Present one command beat, hold it until taken, then record its prediction.
    task automatic send_command(input req_t r, input bit known, input rsp_t typed);
        int   gap;
        int   n;
        run_t lr;
        rsp_t p;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        p = service_request(r);
        pending_results.push_back(known ? typed : p);
        beats_sent++;
        n = blocks_for(r.request_length);
        if (r.command == CMD_ALLOC && p.status == ST_OK && n > 0)
        begin
            lr.first  = p.start_block;
            lr.blocks = n;
            live_runs.push_back(lr);
        end
    endtask

    always @(posedge clk)
    begin : watch_results
        rsp_t exp;
        if (done)
        begin
            if (pending_results.size() == 0)
                report_error($sformatf("result with nothing pending: %p", result));
            else
            begin
                exp = pending_results.pop_front();
                results_seen++;
                status_seen[exp.status]++;
                if (result.status !== exp.status)
                    report_error($sformatf("status: expected %0d, got %0d",
                                           exp.status, result.status));
                if (result.start_block !== exp.start_block)
                    report_error($sformatf("start_block: expected %0d, got %0d",
                                           exp.start_block, result.start_block));
                if (result.entry_address !== exp.entry_address)
                    report_error($sformatf("entry_address: expected %0d, got %0d",
                                           exp.entry_address, result.entry_address));
            end
        end
    end

    initial
    begin
        #6_000_000;
        $display("Timeout: block stopped answering");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        req_t r;
        run_t pr;
        int   pick;
        int   idx;
        int   n_directed;

        // directed: rounding, zero length, full pool, no fit, releases at the edges
        add_row(CMD_ALLOC,     0,  0, 1, ST_OK,      0,   0);
        add_row(CMD_ALLOC,     1,  0, 1, ST_OK,      0,   0);
        add_row(CMD_ALLOC,     4,  0, 1, ST_OK,      1,   4);
        add_row(CMD_ALLOC,     5,  0, 1, ST_OK,      2,   8);
        add_row(CMD_ALLOC,   256,  0, 1, ST_NOFIT,   0,   0);
        add_row(CMD_ALLOC,   511, 63, 1, ST_NOFIT,   0,   0);
        add_row(CMD_RELEASE,   8, 63, 1, ST_BADREL,  0,   0);
        add_row(CMD_RELEASE,   4, 63, 1, ST_OK,     63, 252);
        add_row(CMD_RELEASE,   0,  0, 1, ST_OK,      0,   0);
        add_row(CMD_RELEASE,   4, 10, 1, ST_OK,     10,  40);
        add_row(CMD_RELEASE, 256,  0, 1, ST_OK,      0,   0);
        add_row(CMD_ALLOC,   256,  0, 1, ST_OK,      0,   0);
        add_row(CMD_ALLOC,     1,  0, 1, ST_FULL,    0,   0);
        add_row(CMD_ALLOC,     0, 21, 1, ST_FULL,    0,   0);
        add_row(CMD_RELEASE, 511,  0, 1, ST_BADREL,  0,   0);
        add_row(CMD_RELEASE, 128, 32, 1, ST_OK,     32, 128);
        add_row(CMD_ALLOC,   124,  0, 0, ST_OK,      0,   0);
        add_row(CMD_ALLOC,     8,  0, 0, ST_OK,      0,   0);
        add_row(CMD_ALLOC,     3,  0, 0, ST_OK,      0,   0);
        add_row(CMD_ALLOC,     1,  0, 0, ST_OK,      0,   0);
        add_row(CMD_RELEASE,   1, 63, 0, ST_OK,      0,   0);
        add_row(CMD_ALLOC,     2, 63, 0, ST_OK,      0,   0);
        add_row(CMD_RELEASE, 256,  0, 0, ST_OK,      0,   0);
        add_row(CMD_ALLOC,     0, 42, 0, ST_OK,      0,   0);
        n_directed = directed.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed[i])
            send_command(directed[i].req, directed[i].known, directed[i].rsp);
        live_runs.delete();

        // random: mostly allocate and free of granted runs, some noise releases and pool drops
        for (int k = 0; k < 950; k++)
        begin
            r.release_block = BLK_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 50 || (pick < 85 && live_runs.size() == 0))
            begin
                r.command = CMD_ALLOC;
                idx = $urandom_range(0, 99);
                if (idx < 6)
                    r.request_length = '0;
                else if (idx < 80)
                    r.request_length = LEN_W'($urandom_range(1, 32));
                else if (idx < 95)
                    r.request_length = LEN_W'($urandom_range(33, 256));
                else
                    r.request_length = LEN_W'($urandom_range(257, 511));
            end
            else if (pick < 85)
            begin
                idx = $urandom_range(0, live_runs.size() - 1);
                pr  = live_runs[idx];
                live_runs.delete(idx);
                r.command        = CMD_RELEASE;
                r.release_block  = pr.first;
                // any length that rounds to the same block count
                r.request_length = LEN_W'(pr.blocks * BLOCK_ENTRIES
                                          - $urandom_range(0, BLOCK_ENTRIES - 1));
            end
            else if (pick < 96)
            begin
                r.command = CMD_RELEASE;
                if ($urandom_range(0, 2) == 0)
                    r.request_length = LEN_W'($urandom_range(0, 511));
                else
                    r.request_length = LEN_W'($urandom_range(0, 40));
            end
            else
            begin
                // drop the whole pool
                r.command        = CMD_RELEASE;
                r.release_block  = '0;
                r.request_length = LEN_W'($urandom_range(253, 256));
                live_runs.delete();
            end
            send_command(r, 1'b0, '0);
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (NUM_BLOCKS + 8) @(posedge clk);

        $display("%0d command beats (%0d directed), %0d results checked, %0d errors",
                 beats_sent, n_directed, results_seen, mismatches);
        $display("statuses seen: ok %0d, pool full %0d, no fit %0d, bad release %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NOFIT],
                 status_seen[ST_BADREL]);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
